// File: sv/json_string_unescape_utf8_macros.svh
// Assertion macros shared by the JSON string unescaper modules.
// Included by each file that carries concurrent assertions; no other dependencies.
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define JSU_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define JSU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/jsu_pkg.sv
// Shared types and constants of the JSON string unescaper.
// Used by jsu_front, jsu_queue, jsu_back and the top level; no dependencies.
package jsu_pkg;

   localparam int BYTE_W      = 8;
   localparam int CFG_W       = 10;
   localparam int ENTRY_BYTES = 5;
   localparam int ENTRY_CNT_W = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam logic [CFG_W-1:0] CFG_RESET = 10'd127;

   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LFX   = 8'h66;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UFX   = 8'h46;

   localparam logic [15:0] UTF8_TWO_FROM   = 16'h0080;
   localparam logic [15:0] UTF8_THREE_FROM = 16'h0800;
   localparam logic [7:0]  UTF8_LEAD2      = 8'hC0;
   localparam logic [7:0]  UTF8_LEAD3      = 8'hE0;
   localparam logic [7:0]  UTF8_CONT       = 8'h80;
   localparam logic [7:0]  UTF8_MASK       = 8'h3F;

   typedef struct packed {
      logic [ENTRY_BYTES-1:0][BYTE_W-1:0] bytes;
      logic [ENTRY_CNT_W-1:0]             count;
      logic                               last;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// File: sv/jsu_front.sv
// Front end of the unescaper: escape state, limit check and configuration register.
// Depends on jsu_pkg; pushes finished output groups into jsu_queue.
`include "json_string_unescape_utf8_macros.svh"

module jsu_front #(
   parameter int COUNT_WIDTH = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                req_tlast,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [9:0]          csr_data,
   input  jsu_pkg::qstat_type  qstat,
   output logic                push,
   output jsu_pkg::entry_type  push_entry
);
   import jsu_pkg::*;

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_BSL  = 3'd1;
   localparam logic [2:0] PH_U0   = 3'd2;
   localparam logic [2:0] PH_U1   = 3'd3;
   localparam logic [2:0] PH_U2   = 3'd4;
   localparam logic [2:0] PH_U3   = 3'd5;

   localparam int LIM_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
   localparam logic [LIM_W-1:0] CAP = LIM_W'((1 << COUNT_WIDTH) - 1);

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      if (c inside {[CH_0:CH_9]}) return c[3:0];
      if (c inside {[CH_LA:CH_LFX], [CH_UA:CH_UFX]}) return 4'(c[3:0] + 4'd9);
      return 4'd0;
   endfunction

   function automatic logic [8:0] simple_map(input logic [7:0] c);
      case (c)
         CH_SLASH, CH_QUOTE, CH_BSL: return {1'b1, c};
         CH_N:                       return {1'b1, CH_LF};
         CH_T:                       return {1'b1, CH_TAB};
         CH_R:                       return {1'b1, CH_CR};
         default:                    return 9'd0;
      endcase
   endfunction

   logic [2:0]                         phase_ff, phase_in;
   logic [11:0]                        acc_ff, acc_in;
   logic [2:0][7:0]                    held_ff, held_in;
   logic [COUNT_WIDTH-1:0]             bw_ff, bw_in;
   logic [CFG_W-1:0]                   max_out_ff, max_out_in;

   logic                               accept;
   logic [3:0]                         hexv;
   logic [8:0]                         sm;
   logic [1:0]                         hidx;
   logic [2:0]                         tail_k;
   logic [15:0]                        cp;
   logic [2:0][7:0]                    enc;
   logic [2:0]                         enc_n;
   logic [3:0][7:0]                    tail_b;
   logic [3:0]                         tail_hit;
   logic [3:0][7:0]                    tail_map;
   logic [2:0]                         pos;
   logic                               skip;
   logic [ENTRY_BYTES-1:0][7:0]        cand;
   logic [2:0]                         cand_n;
   logic                               atomic;
   logic [LIM_W-1:0]                   cfg_ext, lim_w;
   logic [COUNT_WIDTH-1:0]             lim, diff;
   logic [2:0]                         room, kept;

   assign accept    = req_tvalid && req_tready;
   assign req_tready = !qstat.full;
   assign csr_ready = 1'b1;

   assign hexv   = hex_val(req_tdata);
   assign sm     = simple_map(req_tdata);
   assign hidx   = 2'(phase_ff - PH_U0);
   assign tail_k = phase_ff - PH_U0;
   assign cp     = {acc_ff, hexv};

   always_comb begin
      enc = '0;
      if (cp < UTF8_TWO_FROM) begin
         enc[0] = cp[7:0];
         enc_n  = 3'd1;
      end else if (cp < UTF8_THREE_FROM) begin
         enc[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
         enc[1] = UTF8_CONT | (cp[7:0] & UTF8_MASK);
         enc_n  = 3'd2;
      end else begin
         enc[0] = UTF8_LEAD3 | {4'h0, cp[15:12]};
         enc[1] = UTF8_CONT | {2'b00, cp[11:6]};
         enc[2] = UTF8_CONT | {2'b00, cp[5:0]};
         enc_n  = 3'd3;
      end
   end

   // Bytes after an unfinished \u at the end of a string, decoded anew.
   always_comb begin
      tail_b[3] = 8'h00;
      for (int j = 0; j < 3; j++) begin
         if (3'(j) < tail_k) begin
            tail_b[j] = held_ff[j];
         end else if (3'(j) == tail_k) begin
            tail_b[j] = req_tdata;
         end else begin
            tail_b[j] = 8'h00;
         end
      end
      for (int j = 0; j < 4; j++) begin
         {tail_hit[j], tail_map[j]} = simple_map(tail_b[j]);
      end
   end

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      held_in  = held_ff;
      cand     = '0;
      cand_n   = 3'd0;
      atomic   = 1'b0;
      pos      = 3'd2;
      skip     = 1'b0;
      if (req_tlast) begin
         case (phase_ff)
            PH_BSL: begin
               if (sm[8]) begin
                  cand[0] = sm[7:0];
                  cand_n  = 3'd1;
               end else begin
                  cand[0] = CH_BSL;
                  cand[1] = req_tdata;
                  cand_n  = 3'd2;
               end
            end
            PH_U0, PH_U1, PH_U2: begin
               cand[0] = CH_BSL;
               cand[1] = CH_U;
               for (int j = 0; j < 3; j++) begin
                  if (3'(j) <= tail_k) begin
                     if (skip) begin
                        skip = 1'b0;
                     end else if (tail_b[j] == CH_BSL && 3'(j) < tail_k && tail_hit[j+1]) begin
                        cand[pos] = tail_map[j+1];
                        pos       = pos + 3'd1;
                        skip      = 1'b1;
                     end else begin
                        cand[pos] = tail_b[j];
                        pos       = pos + 3'd1;
                     end
                  end
               end
               cand_n = pos;
            end
            PH_U3: begin
               cand[2:0] = enc;
               cand_n    = enc_n;
               atomic    = 1'b1;
            end
            default: begin
               cand[0] = req_tdata;
               cand_n  = 3'd1;
            end
         endcase
         phase_in = PH_IDLE;
         acc_in   = '0;
      end else begin
         case (phase_ff)
            PH_BSL: begin
               phase_in = PH_IDLE;
               if (req_tdata == CH_U) begin
                  phase_in = PH_U0;
                  acc_in   = '0;
               end else if (sm[8]) begin
                  cand[0] = sm[7:0];
                  cand_n  = 3'd1;
               end else begin
                  cand[0] = CH_BSL;
                  cand[1] = req_tdata;
                  cand_n  = 3'd2;
               end
            end
            PH_U0, PH_U1, PH_U2: begin
               held_in[hidx] = req_tdata;
               acc_in        = {acc_ff[7:0], hexv};
               phase_in      = phase_ff + 3'd1;
            end
            PH_U3: begin
               cand[2:0] = enc;
               cand_n    = enc_n;
               atomic    = 1'b1;
               phase_in  = PH_IDLE;
               acc_in    = '0;
            end
            default: begin
               if (req_tdata == CH_BSL) begin
                  phase_in = PH_BSL;
               end else begin
                  cand[0]  = req_tdata;
                  cand_n   = 3'd1;
                  phase_in = PH_IDLE;
               end
            end
         endcase
      end
   end

   always_comb begin
      cfg_ext = LIM_W'(max_out_ff);
      lim_w   = (cfg_ext < CAP) ? cfg_ext : CAP;
      lim     = lim_w[COUNT_WIDTH-1:0];
      diff    = lim - bw_ff;
      if (bw_ff >= lim) begin
         room = 3'd0;
      end else if (diff >= COUNT_WIDTH'(ENTRY_BYTES)) begin
         room = 3'(ENTRY_BYTES);
      end else begin
         room = diff[2:0];
      end
      if (atomic) begin
         kept = (cand_n <= room) ? cand_n : 3'd0;
      end else begin
         kept = (cand_n < room) ? cand_n : room;
      end
   end

   assign bw_in      = req_tlast ? '0 : bw_ff + COUNT_WIDTH'(kept);
   assign max_out_in = csr_data;

   assign push             = accept && (kept != 3'd0 || req_tlast);
   assign push_entry.bytes = cand;
   assign push_entry.count = kept;
   assign push_entry.last  = req_tlast;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         acc_ff     <= '0;
         bw_ff      <= '0;
         max_out_ff <= CFG_RESET;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            bw_ff    <= bw_in;
         end
         if (csr_valid && csr_ready) begin
            max_out_ff <= max_out_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

   `JSU_ASSERT_NEXT(a_end_clears, clock, reset, accept && req_tlast,
      bw_ff == '0 && phase_ff == PH_IDLE && acc_ff == '0, "state not cleared at string end")
   `JSU_ASSERT_IMPLY(a_push_room, clock, reset, push, !qstat.full,
      "item pushed into a full queue")

endmodule

// File: sv/jsu_queue.sv
// Short queue of decoded output groups between the front and back ends.
// Depends on jsu_pkg for the entry and status types.
`include "json_string_unescape_utf8_macros.svh"

module jsu_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  jsu_pkg::entry_type  push_entry,
   input  logic                pop,
   output jsu_pkg::entry_type  head,
   output jsu_pkg::qstat_type  qstat
);
   import jsu_pkg::*;

   entry_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign head        = mem_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `JSU_ASSERT_IMPLY(a_no_pop_empty, clock, reset, pop, !qstat.empty,
      "pop from an empty queue")
   `JSU_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= QCNT_W'(QUEUE_DEPTH),
      "queue count beyond depth")
   `JSU_ASSERT_NEXT(a_count_step, clock, reset, push && !pop,
      count_ff == $past(count_ff) + 1'b1, "queue count did not advance on push")

endmodule

// File: sv/jsu_back.sv
// Back end: sends each group's bytes one per cycle while rsp_tready is high.
// Depends on jsu_pkg; reads the head of jsu_queue.
`include "json_string_unescape_utf8_macros.svh"

module jsu_back (
   input  logic                clock,
   input  logic                reset,
   input  jsu_pkg::entry_type  head,
   input  jsu_pkg::qstat_type  qstat,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,   // out_byte
   output logic                rsp_tuser,   // byte_valid
   output logic                rsp_tlast
);
   import jsu_pkg::*;

   logic [ENTRY_CNT_W-1:0] idx_ff, idx_in;
   logic [ENTRY_CNT_W-1:0] last_idx;
   logic                   fire;
   logic                   at_end;

   assign last_idx   = (head.count == '0) ? '0 : head.count - 1'b1;
   assign at_end     = (idx_ff == last_idx);
   assign rsp_tvalid = !qstat.empty;
   assign rsp_tuser  = (head.count != '0);
   assign rsp_tdata  = rsp_tuser ? head.bytes[idx_ff] : 8'h00;
   assign rsp_tlast  = head.last && at_end;
   assign fire       = rsp_tvalid && rsp_tready;
   assign pop        = fire && at_end;

   always_comb begin
      idx_in = idx_ff;
      if (pop) begin
         idx_in = '0;
      end else if (fire) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   `JSU_ASSERT_IMPLY(a_idx_in_group, clock, reset, rsp_tvalid, idx_ff <= last_idx,
      "byte index beyond its group")

endmodule

// File: sv/json_string_unescape_utf8.sv
// Top level of the JSON string unescaper with UTF-8 output.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
//
// The req channel takes one raw byte of a JSON string body per item, with
// req_tlast on the final byte. The rsp channel returns decoded bytes; rsp_tuser
// is low only on the empty end marker sent when the final item of a string
// keeps no bytes, and rsp_tlast marks the last result of each string. csr_data
// sets the most bytes kept per string; csr_ready is always high.
// An item is classified in the cycle it is accepted and its results are
// registered into a four-entry queue, from whose head rsp is driven.
// Items are taken at one per cycle while the queue is not full. The rsp side
// sends one byte per cycle while rsp_tready is high, so an escape that yields
// up to five bytes holds rsp until all are sent; a long run of such items is
// paced by the queue filling. After reset no escape is pending, the byte count
// is zero, the limit is 127 and the queue is empty. When the receiver stalls,
// results wait in the queue; req_tready falls once all four entries are taken.
module json_string_unescape_utf8 #(
   parameter int COUNT_WIDTH = 10
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // out_byte
   output logic       rsp_tuser,    // byte_valid
   output logic       rsp_tlast,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [9:0] csr_data
);
   import jsu_pkg::*;

   entry_type push_entry;
   entry_type head;
   qstat_type qstat;
   logic      push;
   logic      pop;

   jsu_front #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .qstat      (qstat),
      .push       (push),
      .push_entry (push_entry)
   );

   jsu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .qstat      (qstat)
   );

   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .qstat      (qstat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
